// ===== hw/rtl/speck_pkg.sv =====
// ============================================================================
// speck_pkg
// Shared types, constants and rotate helpers for the Speck 48/96 cipher.
// ============================================================================
`default_nettype none

package speck_pkg;

  localparam int unsigned WORD_W      = 24;
  localparam int unsigned BLOCK_W     = 2 * WORD_W;
  localparam int unsigned ROUND_COUNT = 23;
  localparam int unsigned ROT_A       = 8;
  localparam int unsigned ROT_B       = 3;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned STEP_W      = (ROUND_COUNT > 2) ? $clog2(ROUND_COUNT) : 1;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = CFG_IDX_W'(1);

  localparam logic REQ_DECRYPT = 1'b1;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [BLOCK_W-1:0] block_t;
  typedef word_t [ROUND_COUNT-1:0] rk_table_t;

  // one pipeline slot
  typedef struct packed {
    logic  valid;
    logic  dec;
    word_t x;
    word_t y;
  } stage_t;

  function automatic word_t rotr(word_t v, int unsigned r);
    logic [2*WORD_W-1:0] d;
    d = {v, v} >> r;
    return d[WORD_W-1:0];
  endfunction

  function automatic word_t rotl(word_t v, int unsigned r);
    return rotr(v, WORD_W - r);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/speck_key_sched.sv =====
// ============================================================================
// speck_key_sched
// Key registers and iterative round key expansion, one round key per cycle.
// ============================================================================
`default_nettype none

module speck_key_sched (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [speck_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [speck_pkg::BLOCK_W-1:0]    cfg_data,
  output logic                                  running,
  output speck_pkg::rk_table_t                  rk_table
);

  localparam logic [speck_pkg::STEP_W-1:0] LAST_STEP =
    speck_pkg::STEP_W'((speck_pkg::ROUND_COUNT > 1) ? speck_pkg::ROUND_COUNT - 2 : 0);
  localparam logic NEED_EXP = (speck_pkg::ROUND_COUNT > 1);

  speck_pkg::block_t key_low;
  speck_pkg::block_t key_high;
  speck_pkg::block_t key_low_next;
  speck_pkg::block_t key_high_next;
  speck_pkg::block_t seed_low;
  speck_pkg::block_t seed_high;
  logic [speck_pkg::STEP_W-1:0] step;
  logic [speck_pkg::STEP_W-1:0] step_plus;
  speck_pkg::word_t kw;
  speck_pkg::word_t kw_next;
  speck_pkg::word_t l0;
  speck_pkg::word_t l1;
  speck_pkg::word_t l2;
  speck_pkg::word_t t;
  logic cfg_fire;
  logic cfg_hit;
  logic load;

  assign cfg_ready = !running;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_fire &&
                     (cfg_index == speck_pkg::REG_KEY_LOW || cfg_index == speck_pkg::REG_KEY_HIGH);
  assign load      = rst || cfg_hit;

  always_comb begin
    key_low_next  = key_low;
    key_high_next = key_high;
    if (cfg_fire && cfg_index == speck_pkg::REG_KEY_LOW) begin
      key_low_next = cfg_data;
    end
    if (cfg_fire && cfg_index == speck_pkg::REG_KEY_HIGH) begin
      key_high_next = cfg_data;
    end
  end

  // reset expands the all-zero key
  assign seed_low  = rst ? '0 : key_low_next;
  assign seed_high = rst ? '0 : key_high_next;

  assign step_plus = step + speck_pkg::STEP_W'(1);
  assign t         = (speck_pkg::rotr(l0, speck_pkg::ROT_A) + kw) ^ speck_pkg::WORD_W'(step);
  assign kw_next   = speck_pkg::rotl(kw, speck_pkg::ROT_B) ^ t;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_low  <= '0;
      key_high <= '0;
      running  <= NEED_EXP;
      step     <= '0;
    end else if (cfg_fire) begin
      key_low  <= key_low_next;
      key_high <= key_high_next;
      if (cfg_hit) begin
        running <= NEED_EXP;
        step    <= '0;
      end
    end else if (running) begin
      step <= step_plus;
      if (step == LAST_STEP) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kw          <= seed_low[speck_pkg::WORD_W-1:0];
      l0          <= seed_low[speck_pkg::BLOCK_W-1:speck_pkg::WORD_W];
      l1          <= seed_high[speck_pkg::WORD_W-1:0];
      l2          <= seed_high[speck_pkg::BLOCK_W-1:speck_pkg::WORD_W];
      rk_table[0] <= seed_low[speck_pkg::WORD_W-1:0];
    end else if (running) begin
      kw                  <= kw_next;
      l0                  <= l1;
      l1                  <= l2;
      l2                  <= t;
      rk_table[step_plus] <= kw_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/speck_round.sv =====
// ============================================================================
// speck_round
// One registered cipher round, encrypt or decrypt per slot.
// ============================================================================
`default_nettype none

module speck_round (
  input  wire logic              clk,
  input  wire logic              rst,
  input  speck_pkg::stage_t      din,
  input  speck_pkg::word_t       rk_enc,
  input  speck_pkg::word_t       rk_dec,
  output speck_pkg::stage_t      dout
);

  speck_pkg::word_t ex;
  speck_pkg::word_t ey;
  speck_pkg::word_t dx;
  speck_pkg::word_t dy;

  always_comb begin
    ex = (speck_pkg::rotr(din.x, speck_pkg::ROT_A) + din.y) ^ rk_enc;
    ey = speck_pkg::rotl(din.y, speck_pkg::ROT_B) ^ ex;
    dy = speck_pkg::rotr(din.y ^ din.x, speck_pkg::ROT_B);
    dx = speck_pkg::rotl((din.x ^ rk_dec) - dy, speck_pkg::ROT_A);
  end

  // only the valid bit is reset; the data follows it unconditionally
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else begin
      dout.valid <= din.valid;
    end
    dout.dec <= din.dec;
    if (din.dec == speck_pkg::REQ_DECRYPT) begin
      dout.x <= dx;
      dout.y <= dy;
    end else begin
      dout.x <= ex;
      dout.y <= ey;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/speck48_96_block_cipher.sv =====
// ============================================================================
// speck48_96_block_cipher
// Speck 48/96 block cipher, fully unrolled, one round per pipeline stage.
// ============================================================================
// Usage notes:
// - Config channel: cfg_valid/cfg_ready beat carries cfg_index and cfg_data.
//   Index 0 is the low key half (k0, l0), index 1 the high half (l1, l2);
//   other indexes are dropped. Write only while no block is in flight.
// - A key write starts the round key expansion, one round key per cycle,
//   during which cfg_ready is low and busy is high.
// - Reset clears both key halves and runs the same expansion of the
//   all-zero key; busy is high until it is done.
// - Input: a block beat is taken at a clock edge with start high and busy
//   low. req_type selects encrypt (0) or decrypt (1); block_in holds y in
//   bits 23:0 and x in bits 47:24.
// - Output: block_out is valid for exactly one cycle with done high, same
//   word layout. Each block passes through all 23 round stage registers.
// - Throughput: one block per cycle while busy is low; each of the 23 round
//   stages holds one round add/xor/rotate.
// - The receiver cannot stall, so the pipeline always advances.
// ============================================================================
`default_nettype none

module speck48_96_block_cipher (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic                             req_type,
  input  wire logic [speck_pkg::BLOCK_W-1:0]    block_in,
  output logic                                  done,
  output logic [speck_pkg::BLOCK_W-1:0]         block_out,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [speck_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [speck_pkg::BLOCK_W-1:0]    cfg_data
);

  speck_pkg::rk_table_t rk_table;
  speck_pkg::stage_t    stage [speck_pkg::ROUND_COUNT+1];
  logic                 running;

  speck_key_sched u_key_sched (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .running   (running),
    .rk_table  (rk_table)
  );

  assign busy = running;

  // stage 0 is the accepted beat, unregistered
  always_comb begin
    stage[0].valid = start && !busy;
    stage[0].dec   = req_type;
    stage[0].x     = block_in[speck_pkg::BLOCK_W-1:speck_pkg::WORD_W];
    stage[0].y     = block_in[speck_pkg::WORD_W-1:0];
  end

  // decrypt walks the round keys in reverse order
  for (genvar i = 0; i < speck_pkg::ROUND_COUNT; i++) begin : g_round
    speck_round u_round (
      .clk    (clk),
      .rst    (rst),
      .din    (stage[i]),
      .rk_enc (rk_table[i]),
      .rk_dec (rk_table[speck_pkg::ROUND_COUNT-1-i]),
      .dout   (stage[i+1])
    );
  end

  // last stage register is the output register
  assign done      = stage[speck_pkg::ROUND_COUNT].valid;
  assign block_out = {stage[speck_pkg::ROUND_COUNT].x, stage[speck_pkg::ROUND_COUNT].y};

endmodule

`default_nettype wire

// ===== tb/speck48_96_block_cipher_test.sv =====
// ============================================================================
// speck48_96_block_cipher_test
// Self-checking bench for the Speck 48/96 cipher. A directed table comes
// first: extreme blocks, both directions, the published key and block pair,
// and writes to unused register indexes. Random phases follow, each under a
// new key. Each done beat is checked against a cipher model or typed result.
// ============================================================================
module speck48_96_block_cipher_test;
  timeunit 1ns;
  timeprecision 1ps;

  import speck_pkg::*;

  // --------------------------------------------------------------------------
  // Codes and run limits
  // --------------------------------------------------------------------------
  localparam logic                 OP_ENCRYPT  = 1'b0;
  // indexes past the two key halves; the block must drop these writes
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  localparam int IDLE_PCT       = 26;    // chance per cycle of a sender gap
  localparam int PHASE_COUNT    = 8;
  localparam int PHASE_ITEMS    = 43;
  localparam int STEADY_ITEMS   = 100;   // the phase with no gaps at all
  localparam int STEADY_PHASE   = 3;
  localparam int TAIL_CYCLES    = 40;    // 23 round stages plus margin
  // worst quiet span: key expansion + round pipe + sender gaps
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic {ROW_KEY, ROW_BLOCK} row_kind_t;

  // One line of the directed table. Key rows use idx/data, block rows use
  // op/data and may carry a hand-typed result in want.
  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic                 op;
    block_t               data;
    logic                 typed;
    block_t               want;
  } stim_row_t;

  // --------------------------------------------------------------------------
  // Clock, reset and the block's ports
  // --------------------------------------------------------------------------
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 start     = 1'b0;
  logic                 req_type  = 1'b0;
  block_t               block_in  = '0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  block_t               cfg_data  = '0;
  logic                 busy;
  logic                 done;
  logic                 cfg_ready;
  block_t               block_out;

  always #6 clk = ~clk;

  speck48_96_block_cipher u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .block_in  (block_in),
    .done      (done),
    .block_out (block_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Cipher model: its own key halves and round key table
  // --------------------------------------------------------------------------
  block_t key_lo;
  block_t key_hi;
  word_t  round_keys [ROUND_COUNT];

  function automatic word_t ror24(word_t v, int unsigned r);
    return (v >> r) | (v << (WORD_W - r));
  endfunction

  function automatic word_t rol24(word_t v, int unsigned r);
    return (v << r) | (v >> (WORD_W - r));
  endfunction

  // k0 from key_lo[23:0]; l0, l1, l2 follow and slide down one per round
  function automatic void build_schedule();
    word_t k;
    word_t l0;
    word_t l1;
    word_t l2;
    word_t t;
    k  = key_lo[WORD_W-1:0];
    l0 = key_lo[BLOCK_W-1:WORD_W];
    l1 = key_hi[WORD_W-1:0];
    l2 = key_hi[BLOCK_W-1:WORD_W];
    round_keys[0] = k;
    for (int i = 0; i < ROUND_COUNT - 1; i++) begin
      t  = (ror24(l0, ROT_A) + k) ^ word_t'(i);
      k  = rol24(k, ROT_B) ^ t;
      l0 = l1;
      l1 = l2;
      l2 = t;
      round_keys[i + 1] = k;
    end
  endfunction

  function automatic block_t speck_transform(logic op, block_t blk);
    word_t x;
    word_t y;
    x = blk[BLOCK_W-1:WORD_W];
    y = blk[WORD_W-1:0];
    if (op == REQ_DECRYPT) begin
      // inverse rounds, last round key first
      for (int i = ROUND_COUNT - 1; i >= 0; i--) begin
        y = ror24(y ^ x, ROT_B);
        x = rol24((x ^ round_keys[i]) - y, ROT_A);
      end
    end else begin
      for (int i = 0; i < ROUND_COUNT; i++) begin
        x = (ror24(x, ROT_A) + y) ^ round_keys[i];
        y = rol24(y, ROT_B) ^ x;
      end
    end
    return {x, y};
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard. Tracks key beats and block beats at the edge they are taken,
  // and checks each done beat against the oldest expected block.
  // --------------------------------------------------------------------------
  block_t expected_blocks [$];
  block_t head_block;
  logic   want_typed = 1'b0;   // travels with the block beat
  block_t want_block = '0;
  int     items_sent   = 0;
  int     results_seen = 0;
  int     fail_count   = 0;
  int     quiet_cycles = 0;
  int     idle_pct     = IDLE_PCT;

  always @(posedge clk) begin
    if (rst) begin
      key_lo = '0;
      key_hi = '0;
      build_schedule();
    end else begin
      if (done) begin
        if (expected_blocks.size() == 0) begin
          fail_count++;
          $display("%0t ns: done beat with nothing expected, got %h", $time, block_out);
        end else begin
          head_block = expected_blocks.pop_front();
          results_seen++;
          if (block_out !== head_block) begin
            fail_count++;
            $display("%0t ns: block_out expected %h, got %h",
                     $time, head_block, block_out);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY_LOW: begin
            key_lo = cfg_data;
            build_schedule();
          end
          REG_KEY_HIGH: begin
            key_hi = cfg_data;
            build_schedule();
          end
          default: ;   // unused index: dropped
        endcase
      end
      if (start && !busy) begin
        expected_blocks.push_back(want_typed ? want_block
                                             : speck_transform(req_type, block_in));
      end
    end
  end

  // Watchdog: too long without any beat on any channel ends the run.
  always @(posedge clk) begin
    if ((start && !busy) || (cfg_valid && cfg_ready) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("speck48_96_block_cipher verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers. All drive with nonblocking assignments just after an edge.
  // start and cfg_valid stay high across back-to-back beats; they drop only
  // for a gap or a change of channel, so no signal is assigned twice in a step.
  // --------------------------------------------------------------------------
  task automatic send_block(input logic op, input block_t blk,
                            input logic typed, input block_t want);
    cfg_valid <= 1'b0;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start      <= 1'b1;
    req_type   <= op;
    block_in   <= blk;
    want_typed <= typed;
    want_block <= want;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  // Lets the round pipe empty: every block sent has come back.
  task automatic wait_idle();
    start <= 1'b0;
    while (results_seen != items_sent) @(posedge clk);
  endtask

  task automatic write_key_reg(input logic [CFG_IDX_W-1:0] idx, input block_t data);
    wait_idle();
    if ($urandom_range(99) < idle_pct) begin
      cfg_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  stim_row_t directed_rows [$];

  initial begin
    stim_row_t row;
    block_t    blk;
    int        count;

    // Directed table. First block rows run under the all-zero key left by
    // reset; the published pair is typed in with its expected result.
    directed_rows.push_back('{ROW_BLOCK, REG_KEY_LOW, OP_ENCRYPT, '0, 1'b0, '0});
    directed_rows.push_back('{ROW_BLOCK, REG_KEY_LOW, OP_ENCRYPT, '1, 1'b0, '0});
    directed_rows.push_back('{ROW_BLOCK, REG_KEY_LOW, REQ_DECRYPT, '0, 1'b0, '0});
    directed_rows.push_back('{ROW_BLOCK, REG_KEY_LOW, REQ_DECRYPT, '1, 1'b0, '0});
    directed_rows.push_back('{ROW_BLOCK, REG_KEY_LOW, OP_ENCRYPT,
                              48'hFFFFFF_000000, 1'b0, '0});
    directed_rows.push_back('{ROW_BLOCK, REG_KEY_LOW, REQ_DECRYPT,
                              48'h000000_FFFFFF, 1'b0, '0});
    directed_rows.push_back('{ROW_BLOCK, REG_KEY_LOW, OP_ENCRYPT,
                              48'hAAAAAA_555555, 1'b0, '0});
    directed_rows.push_back('{ROW_KEY, REG_KEY_LOW, OP_ENCRYPT,
                              48'h0A0908_020100, 1'b0, '0});
    directed_rows.push_back('{ROW_KEY, REG_KEY_HIGH, OP_ENCRYPT,
                              48'h1A1918_121110, 1'b0, '0});
    directed_rows.push_back('{ROW_BLOCK, REG_KEY_LOW, OP_ENCRYPT,
                              48'h6D2073_696874, 1'b1, 48'h735E10_B6445D});
    directed_rows.push_back('{ROW_BLOCK, REG_KEY_LOW, REQ_DECRYPT,
                              48'h735E10_B6445D, 1'b1, 48'h6D2073_696874});
    // writes to unused indexes must leave the key alone
    directed_rows.push_back('{ROW_KEY, REG_SPARE_A, OP_ENCRYPT, '1, 1'b0, '0});
    directed_rows.push_back('{ROW_KEY, REG_SPARE_B, OP_ENCRYPT,
                              48'h123456_789ABC, 1'b0, '0});
    directed_rows.push_back('{ROW_BLOCK, REG_KEY_LOW, OP_ENCRYPT,
                              48'h6D2073_696874, 1'b1, 48'h735E10_B6445D});
    directed_rows.push_back('{ROW_KEY, REG_KEY_LOW, OP_ENCRYPT, '1, 1'b0, '0});
    directed_rows.push_back('{ROW_KEY, REG_KEY_HIGH, OP_ENCRYPT, '1, 1'b0, '0});
    directed_rows.push_back('{ROW_BLOCK, REG_KEY_LOW, OP_ENCRYPT, '0, 1'b0, '0});
    directed_rows.push_back('{ROW_BLOCK, REG_KEY_LOW, OP_ENCRYPT, '1, 1'b0, '0});
    directed_rows.push_back('{ROW_BLOCK, REG_KEY_LOW, REQ_DECRYPT, '0, 1'b0, '0});
    directed_rows.push_back('{ROW_BLOCK, REG_KEY_LOW, REQ_DECRYPT, '1, 1'b0, '0});
    // one half changed on its own: the schedule must pick up both halves
    directed_rows.push_back('{ROW_KEY, REG_KEY_LOW, OP_ENCRYPT, '0, 1'b0, '0});
    directed_rows.push_back('{ROW_BLOCK, REG_KEY_LOW, OP_ENCRYPT,
                              48'h555555_AAAAAA, 1'b0, '0});
    directed_rows.push_back('{ROW_BLOCK, REG_KEY_LOW, REQ_DECRYPT,
                              48'hFFFFFF_000000, 1'b0, '0});

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_KEY) begin
        write_key_reg(row.idx, row.data);
      end else begin
        send_block(row.op, row.data, row.typed, row.want);
      end
    end

    // Random phases, each under a fresh key; the first two use the extremes.
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin
          write_key_reg(REG_KEY_LOW, '0);
          write_key_reg(REG_KEY_HIGH, '0);
        end
        1: begin
          write_key_reg(REG_KEY_HIGH, '1);
          write_key_reg(REG_KEY_LOW, '1);
        end
        default: begin
          write_key_reg(REG_KEY_LOW, block_t'({$urandom(), $urandom()}));
          write_key_reg(REG_KEY_HIGH, block_t'({$urandom(), $urandom()}));
        end
      endcase
      if (phase % 3 == 2) begin
        write_key_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
                      block_t'({$urandom(), $urandom()}));
      end

      // one long back-to-back stretch keeps every round stage full
      idle_pct = (phase == STEADY_PHASE) ? 0 : IDLE_PCT;
      count    = (phase == STEADY_PHASE) ? STEADY_ITEMS : PHASE_ITEMS;
      for (int n = 0; n < count; n++) begin
        case ($urandom_range(11))
          0:       blk = '0;
          1:       blk = '1;
          2:       blk = {word_t'($urandom()), {WORD_W{1'b0}}};
          3:       blk = {{WORD_W{1'b1}}, word_t'($urandom())};
          default: blk = block_t'({$urandom(), $urandom()});
        endcase
        send_block(1'($urandom_range(1)), blk, 1'b0, '0);
      end
    end

    // Drain the pipe, then watch a little longer for stray done beats.
    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("speck48_96_block_cipher verification clean");
    end else begin
      $display("speck48_96_block_cipher verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/speck_pkg.sv
hw/rtl/speck_key_sched.sv
hw/rtl/speck_round.sv
hw/rtl/speck48_96_block_cipher.sv
tb/speck48_96_block_cipher_test.sv
